FILE: sv/rau_pkg.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Opcodes, comparison codes, queue depth and the flag group that travels with
// every classified item from the front end to the back end.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam logic [2:0] OP_MAKE = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;
    localparam logic [2:0] OP_CMP  = 3'd5;

    localparam logic [1:0] CMP_LESS    = 2'd0;
    localparam logic [1:0] CMP_EQUAL   = 2'd1;
    localparam logic [1:0] CMP_GREATER = 2'd2;
    localparam logic [1:0] CMP_NONE    = 2'd3;

    localparam int QUEUE_DEPTH = 2;

    // res_ok: result may be valid (for a compare: the order is defined).
    typedef struct packed {
        logic res_ok;
        logic is_cmp;
        logic den_neg;
        logic t0_neg;
        logic t1_neg;
    } t_flags;

endpackage

FILE: sv/rau_if.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit channels
// Operand channel and result channel, each with valid, ready and payload.
// ----------------------------------------------------------------------------
interface rau_in_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic [2:0]          opcode;
    logic signed [W-1:0] a_num;
    logic signed [W-1:0] a_den;
    logic                a_valid;
    logic signed [W-1:0] b_num;
    logic [W-2:0]        b_den;
    logic                b_valid;

    modport source (output valid, opcode, a_num, a_den, a_valid, b_num, b_den, b_valid,
                    input ready);
    modport sink   (input valid, opcode, a_num, a_den, a_valid, b_num, b_den, b_valid,
                    output ready);
endinterface

interface rau_out_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic signed [2*W:0] res_num;
    logic [2*W-2:0]      res_den;
    logic                res_valid;
    logic [1:0]          cmp_code;

    modport source (output valid, res_num, res_den, res_valid, cmp_code, input ready);
    modport sink   (input valid, res_num, res_den, res_valid, cmp_code, output ready);
endinterface

FILE: sv/rau_front.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit front end
// Accepts operand transfers, splits operands into sign and magnitude and
// decodes the opcode into three multiplier operand pairs and a flag group.
// ----------------------------------------------------------------------------
module rau_front #(
    parameter int W = 16
) (
    rau_in_if.sink               i_in,
    input  logic                 i_full,
    output logic                 o_push,
    output rau_pkg::t_flags      o_flags,
    output logic [5:0][W-1:0]    o_ops
);
    import rau_pkg::*;

    logic         an_neg, ad_neg, bn_neg;
    logic [W-1:0] an_mag, ad_mag, bn_mag, bd_mag;
    logic [W-1:0] one;

    assign one    = W'(1);
    assign an_neg = i_in.a_num[W-1];
    assign ad_neg = i_in.a_den[W-1];
    assign bn_neg = i_in.b_num[W-1];
    assign an_mag = an_neg ? W'(-i_in.a_num) : W'(i_in.a_num);
    assign ad_mag = ad_neg ? W'(-i_in.a_den) : W'(i_in.a_den);
    assign bn_mag = bn_neg ? W'(-i_in.b_num) : W'(i_in.b_num);
    assign bd_mag = {1'b0, i_in.b_den};

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    // Pair 0 and pair 1 are the two numerator terms, pair 2 the denominator.
    always_comb begin
        o_ops   = '0;
        o_flags = '0;
        unique case (i_in.opcode) inside
            OP_MAKE: begin
                o_ops[0] = an_mag;  o_ops[1] = one;
                o_ops[4] = ad_mag;  o_ops[5] = one;
                o_flags.t0_neg  = an_neg;
                o_flags.den_neg = ad_neg;
                o_flags.res_ok  = 1'b1;
            end
            OP_ADD, OP_SUB: begin
                o_ops[0] = an_mag;  o_ops[1] = bd_mag;
                o_ops[2] = bn_mag;  o_ops[3] = ad_mag;
                o_ops[4] = ad_mag;  o_ops[5] = bd_mag;
                o_flags.t0_neg  = an_neg;
                o_flags.t1_neg  = bn_neg ^ ad_neg ^ (i_in.opcode == OP_SUB);
                o_flags.den_neg = ad_neg;
                o_flags.res_ok  = i_in.a_valid && i_in.b_valid;
            end
            OP_MUL: begin
                o_ops[0] = an_mag;  o_ops[1] = bn_mag;
                o_ops[4] = ad_mag;  o_ops[5] = bd_mag;
                o_flags.t0_neg  = an_neg ^ bn_neg;
                o_flags.den_neg = ad_neg;
                o_flags.res_ok  = i_in.a_valid && i_in.b_valid;
            end
            OP_DIV: begin
                o_ops[0] = an_mag;  o_ops[1] = bd_mag;
                o_ops[4] = ad_mag;  o_ops[5] = bn_mag;
                o_flags.t0_neg  = an_neg ^ bn_neg;
                o_flags.den_neg = ad_neg;
                o_flags.res_ok  = i_in.a_valid && i_in.b_valid && (bn_mag != '0);
            end
            OP_CMP: begin
                // Left side minus right side; its sign gives the order.
                o_ops[0] = an_mag;  o_ops[1] = bd_mag;
                o_ops[2] = bn_mag;  o_ops[3] = ad_mag;
                o_flags.is_cmp = 1'b1;
                o_flags.t0_neg = an_neg ^ ad_neg;
                o_flags.t1_neg = !bn_neg;
                o_flags.res_ok = i_in.a_valid && i_in.b_valid &&
                                 (ad_mag != '0) && (bd_mag != '0);
            end
            default: begin
                o_ops   = '0;
                o_flags = '0;
            end
        endcase
    end

endmodule

FILE: sv/rau_queue.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module rau_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

FILE: sv/rau_back.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit back end
// Sequencer with one shared multiplier, a signed adder, a binary gcd and a
// dual restoring divider that reduces numerator and denominator together.
// ----------------------------------------------------------------------------
module rau_back #(
    parameter int W = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  rau_pkg::t_flags   i_flags,
    input  logic [5:0][W-1:0] i_ops,
    output logic              o_pop,
    rau_out_if.source         o_out
);
    import rau_pkg::*;

    localparam int MW = 2 * W;
    localparam int SW = 2 * W + 2;
    localparam int NW = 2 * W + 1;
    localparam int DW = 2 * W - 1;
    localparam int KW = $clog2(MW);
    localparam logic [1:0] MUL_LAST = 2'd2;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_SUM  = 6'b000100,
        S_GCD  = 6'b001000,
        S_DIV  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state            r_st, n_st;
    logic [1:0]        r_mcnt;
    t_flags            r_flags;
    logic [5:0][W-1:0] r_ops;
    logic [MW-1:0]     r_p0, r_p1, r_p2;
    logic [MW-1:0]     r_u, r_v, r_g;
    logic [KW-1:0]     r_k;
    logic [MW-1:0]     r_qn, r_qd, r_rn, r_rd;
    logic [KW-1:0]     r_dcnt;
    logic              r_neg;
    logic [MW-1:0]     r_res_mag;
    logic              r_res_neg;
    logic [DW-1:0]     r_res_den;
    logic              r_res_valid;
    logic [1:0]        r_cmp;

    logic [W-1:0]         mul_a, mul_b;
    logic [MW-1:0]        prod;
    logic signed [SW-1:0] v0, v1, sum;
    logic [SW-1:0]        sum_abs;
    logic [MW-1:0]        nmag;
    logic                 sum_neg;
    logic [MW:0]          tn, td, gx;
    logic                 bit_n, bit_d;
    logic [MW-1:0]        qn_next, qd_next;
    logic [NW-1:0]        res_ext;

    assign o_pop = (r_st == S_IDLE) && !i_empty;

    // Shared multiplier, one operand pair a cycle.
    always_comb begin
        case (r_mcnt)
            2'd0:    begin mul_a = r_ops[0]; mul_b = r_ops[1]; end
            2'd1:    begin mul_a = r_ops[2]; mul_b = r_ops[3]; end
            default: begin mul_a = r_ops[4]; mul_b = r_ops[5]; end
        endcase
    end
    assign prod = MW'(mul_a) * MW'(mul_b);

    always_comb begin
        v0 = $signed({2'b00, r_p0});
        v1 = $signed({2'b00, r_p1});
        if (r_flags.t0_neg) v0 = -v0;
        if (r_flags.t1_neg) v1 = -v1;
        sum     = v0 + v1;
        sum_neg = sum[SW-1];
        sum_abs = sum_neg ? SW'(-sum) : SW'(sum);
        nmag    = sum_abs[MW-1:0];
    end

    // One restoring step for each dividend against the common gcd.
    assign gx      = {1'b0, r_g};
    assign tn      = {r_rn, r_qn[MW-1]};
    assign td      = {r_rd, r_qd[MW-1]};
    assign bit_n   = (tn >= gx);
    assign bit_d   = (td >= gx);
    assign qn_next = {r_qn[MW-2:0], bit_n};
    assign qd_next = {r_qd[MW-2:0], bit_d};

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: if (!i_empty) n_st = S_MUL;
            S_MUL:  if (r_mcnt == MUL_LAST) n_st = S_SUM;
            S_SUM: begin
                if (r_flags.is_cmp || !r_flags.res_ok || (r_p2 == '0)) n_st = S_OUT;
                else n_st = S_GCD;
            end
            S_GCD:  if (r_u == '0) n_st = S_DIV;
            S_DIV:  if (r_dcnt == KW'(MW - 1)) n_st = S_OUT;
            S_OUT:  if (o_out.ready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_mcnt <= '0;
        end else begin
            r_st <= n_st;
            if (o_pop) r_mcnt <= '0;
            else if (r_st == S_MUL) r_mcnt <= r_mcnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            S_IDLE: begin
                r_ops   <= i_ops;
                r_flags <= i_flags;
            end
            S_MUL: begin
                case (r_mcnt)
                    2'd0:    r_p0 <= prod;
                    2'd1:    r_p1 <= prod;
                    default: r_p2 <= prod;
                endcase
            end
            S_SUM: begin
                r_res_mag   <= '0;
                r_res_neg   <= 1'b0;
                r_res_den   <= '0;
                r_res_valid <= 1'b0;
                r_cmp       <= CMP_NONE;
                if (r_flags.is_cmp && r_flags.res_ok) begin
                    if (sum_neg)        r_cmp <= CMP_LESS;
                    else if (sum == '0) r_cmp <= CMP_EQUAL;
                    else                r_cmp <= CMP_GREATER;
                end
                r_u   <= nmag;
                r_v   <= r_p2;
                r_k   <= '0;
                r_qn  <= nmag;
                r_qd  <= r_p2;
                r_neg <= (nmag != '0) && (sum_neg ^ r_flags.den_neg);
            end
            S_GCD: begin
                if (r_u == '0) begin
                    r_g    <= r_v << r_k;
                    r_rn   <= '0;
                    r_rd   <= '0;
                    r_dcnt <= '0;
                end else if (!r_u[0] && !r_v[0]) begin
                    r_u <= r_u >> 1;
                    r_v <= r_v >> 1;
                    r_k <= r_k + KW'(1);
                end else if (!r_u[0]) begin
                    r_u <= r_u >> 1;
                end else if (!r_v[0]) begin
                    r_v <= r_v >> 1;
                end else if (r_u >= r_v) begin
                    r_u <= (r_u - r_v) >> 1;
                end else begin
                    r_v <= (r_v - r_u) >> 1;
                end
            end
            S_DIV: begin
                r_rn   <= bit_n ? MW'(tn - gx) : MW'(tn);
                r_rd   <= bit_d ? MW'(td - gx) : MW'(td);
                r_qn   <= qn_next;
                r_qd   <= qd_next;
                r_dcnt <= r_dcnt + KW'(1);
                if (r_dcnt == KW'(MW - 1)) begin
                    r_res_mag   <= qn_next;
                    r_res_neg   <= r_neg;
                    r_res_den   <= qd_next[DW-1:0];
                    r_res_valid <= 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign res_ext         = {1'b0, r_res_mag};
    assign o_out.valid     = (r_st == S_OUT);
    assign o_out.res_num   = r_res_neg ? $signed(-res_ext) : $signed(res_ext);
    assign o_out.res_den   = r_res_den;
    assign o_out.res_valid = r_res_valid;
    assign o_out.cmp_code  = r_cmp;

    a_gcd_v_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_GCD) |-> (r_v != '0))
        else $error("gcd operand became zero");
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_DIV) |-> (r_g != '0))
        else $error("divider started with zero gcd");
    a_valid_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.res_valid) |-> (o_out.res_den != '0))
        else $error("valid result with zero denominator");
    a_pop_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_st == S_MUL) && (r_mcnt == 2'd0))
        else $error("pop did not start the multiply sequence");

endmodule

FILE: sv/rational_arithmetic_unit_top.sv
// Sequence after an operand transfer: take it from the queue, multiply the three
// operand pairs, add, run a binary gcd and the dual divide, then the output state;
// compares, invalid results and zero denominators skip gcd and divide.
// One item is in the back end at a time; the queue keeps taking transfers until
// it is full. Reset: synchronous, active low.
// ----------------------------------------------------------------------------
// Rational arithmetic unit top level
// Exact make, add, subtract, multiply, divide and compare of signed
// rationals, with results reduced by the gcd and the sign on the numerator.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_top #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rau_in_if.sink    i_in,
    rau_out_if.source o_out
);
    import rau_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int QW = $bits(t_flags) + 6 * W;

    // The front end classifies each operand transfer into operand pairs for
    // the shared multiplier and a flag group, and pushes it into the queue.
    logic              push, pop, full, empty;
    t_flags            f_flags, b_flags;
    logic [5:0][W-1:0] f_ops, b_ops;
    logic [QW-1:0]     q_out;

    rau_front #(.W(W)) u_front (
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_flags (f_flags),
        .o_ops   (f_ops)
    );

    // The queue lets the front end take new transfers while the back end is
    // still busy with a long gcd or divide, or waits on its output.
    rau_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_flags, f_ops}),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_data  (q_out)
    );

    assign b_flags = q_out[QW-1 -: $bits(t_flags)];
    assign b_ops   = q_out[6*W-1:0];

    // The back end runs each item through multiply, add and (for reducible results)
    // gcd and divide, and holds the finished result in its output register until transferred.
    rau_back #(.W(W)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_flags (b_flags),
        .i_ops   (b_ops),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
